>>> src/hwt_pkg.sv
// ----------------------------------------------------------------------------
// HTML word tokenizer package
// Shared types, character codes and keyword lookups for the tokenizer.
// ----------------------------------------------------------------------------
package hwt_pkg;

	localparam int DEPTH_W = 16;
	localparam int LEN_W   = 3;
	localparam int CHAR_W  = 7;

	localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 16'sh7FFF;
	localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = 16'sh8000;
	localparam logic signed [DEPTH_W-1:0] DEPTH_ZERO = 16'sh0000;

	localparam logic [7:0] CH_LT      = 8'h3C;  // '<'
	localparam logic [7:0] CH_GT      = 8'h3E;  // '>'
	localparam logic [7:0] CH_UPPER_A = 8'h41;  // 'A'
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;  // 'a'
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;

	localparam logic [LEN_W-1:0] LEN_STYLE  = 3'd5;
	localparam logic [LEN_W-1:0] LEN_SCRIPT = 3'd6;
	localparam logic [LEN_W-1:0] LEN_MAX    = 3'd7;

	typedef struct packed {
		logic signed [DEPTH_W-1:0] tag_depth;
		logic                      skip_text;
		logic [LEN_W-1:0]          word_length;
		logic                      style_prefix_ok;
		logic                      script_prefix_ok;
	} hwt_state_t;

	localparam hwt_state_t STATE_RESET = '{
		tag_depth:        DEPTH_ZERO,
		skip_text:        1'b0,
		word_length:      '0,
		style_prefix_ok:  1'b1,
		script_prefix_ok: 1'b1
	};

	typedef struct packed {
		logic              valid;
		logic [CHAR_W-1:0] word_char;
		logic              word_end;
	} hwt_result_t;

	// Letter of "style" at a position; zero past its end never matches a word byte.
	function automatic logic [CHAR_W-1:0] style_char(input logic [LEN_W-1:0] pos);
		logic [CHAR_W-1:0] ch;
		unique case (pos)
			3'd0:    ch = 7'h73;  // s
			3'd1:    ch = 7'h74;  // t
			3'd2:    ch = 7'h79;  // y
			3'd3:    ch = 7'h6C;  // l
			3'd4:    ch = 7'h65;  // e
			default: ch = 7'h00;
		endcase
		return ch;
	endfunction

	// Letter of "script" at a position.
	function automatic logic [CHAR_W-1:0] script_char(input logic [LEN_W-1:0] pos);
		logic [CHAR_W-1:0] ch;
		unique case (pos)
			3'd0:    ch = 7'h73;  // s
			3'd1:    ch = 7'h63;  // c
			3'd2:    ch = 7'h72;  // r
			3'd3:    ch = 7'h69;  // i
			3'd4:    ch = 7'h70;  // p
			3'd5:    ch = 7'h74;  // t
			default: ch = 7'h00;
		endcase
		return ch;
	endfunction

endpackage

>>> src/hwt_step.sv
// ----------------------------------------------------------------------------
// HTML word tokenizer step logic
// Computes the next tokenizer state and the optional result for one byte.
// ----------------------------------------------------------------------------
module hwt_step import hwt_pkg::*; (
	input  logic [7:0]  text_byte,
	input  logic        doc_end,
	input  hwt_state_t  cur,
	output hwt_state_t  nxt,
	output hwt_result_t res
);

	logic              is_lower;
	logic              is_upper;
	logic              is_digit;
	logic              emitted;
	logic [7:0]        folded;
	logic [CHAR_W-1:0] ch;

	assign is_lower = (text_byte >= CH_LOWER_A) && (text_byte <= CH_LOWER_Z);
	assign is_upper = (text_byte >= CH_UPPER_A) && (text_byte <= CH_UPPER_Z);
	assign is_digit = (text_byte >= CH_DIGIT_0) && (text_byte <= CH_DIGIT_9);
	assign folded   = is_upper ? (text_byte - CH_UPPER_A + CH_LOWER_A) : text_byte;
	assign ch       = folded[CHAR_W-1:0];
	assign emitted  = (cur.tag_depth == DEPTH_ZERO) && !cur.skip_text;

	always_comb begin
		nxt = cur;
		res = '0;
		if (doc_end) begin
			// Flush a pending visible word, then start over.
			res.valid    = (cur.word_length != '0) && emitted;
			res.word_end = 1'b1;
			nxt          = STATE_RESET;
		end else if (is_lower || is_upper || is_digit) begin
			if (cur.word_length >= LEN_STYLE || style_char(cur.word_length) != ch) begin
				nxt.style_prefix_ok = 1'b0;
			end
			if (cur.word_length >= LEN_SCRIPT || script_char(cur.word_length) != ch) begin
				nxt.script_prefix_ok = 1'b0;
			end
			if (cur.word_length != LEN_MAX) begin
				nxt.word_length = cur.word_length + 3'd1;
			end
			res.valid     = emitted;
			res.word_char = ch;
		end else begin
			if (cur.tag_depth == DEPTH_ZERO) begin
				res.valid    = (cur.word_length != '0) && !cur.skip_text;
				res.word_end = 1'b1;
			end else if ((cur.style_prefix_ok && cur.word_length == LEN_STYLE) ||
					(cur.script_prefix_ok && cur.word_length == LEN_SCRIPT)) begin
				nxt.skip_text = 1'b1;
			end
			if (text_byte == CH_LT) begin
				if (cur.tag_depth != DEPTH_MAX) begin
					nxt.tag_depth = cur.tag_depth + 16'sd1;
				end
				nxt.skip_text = 1'b0;
			end else if (text_byte == CH_GT) begin
				if (cur.tag_depth != DEPTH_MIN) begin
					nxt.tag_depth = cur.tag_depth - 16'sd1;
				end
			end
			nxt.word_length      = '0;
			nxt.style_prefix_ok  = 1'b1;
			nxt.script_prefix_ok = 1'b1;
		end
	end

endmodule

>>> src/hwt_out_reg.sv
// ----------------------------------------------------------------------------
// HTML word tokenizer output register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module hwt_out_reg import hwt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  hwt_result_t       res,
	output logic              take,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CHAR_W-1:0] word_char,
	output logic              word_end
);

	logic              valid_q;
	logic [CHAR_W-1:0] char_q;
	logic              end_q;

	// The register can load whenever it is empty or being drained.
	assign take = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res.valid) begin
			char_q <= res.word_char;
			end_q  <= res.word_end;
		end
	end

	assign out_valid = valid_q;
	assign word_char = char_q;
	assign word_end  = end_q;

endmodule

>>> src/html_word_tokenizer.sv
// ----------------------------------------------------------------------------
// HTML word tokenizer
// Streams lowercased words found outside tags, one byte per transaction.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+--------------------------------
//  input   | in        | in_valid / in_ready  | text_byte[7:0], doc_end
//  output  | out       | out_valid / out_ready| word_char[6:0], word_end
//
// Each input transaction is captured in an input register (_s1). From there
// the step logic reads that byte and the tokenizer state, updates the
// state and loads at most one result into the output register, so one byte
// per cycle is sustained while out_ready stays high. A byte that yields no
// result still passes through the same stage.
// A stall on the output holds the input register, and in_ready then follows
// out_ready. Reset empties both registers and returns the state to its
// initial values (depth zero, no skipping, no word pending).
module html_word_tokenizer import hwt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        text_byte,
	input  logic              doc_end,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CHAR_W-1:0] word_char,
	output logic              word_end
);

	// Input register.
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        doc_end_s1;

	// Tokenizer state, committed when the captured byte is processed.
	hwt_state_t  state_q;
	hwt_state_t  state_nxt;

	hwt_result_t step_res;
	hwt_result_t out_res;
	logic        take;
	logic        advance;

	// The captured byte is consumed whenever the output register can load.
	assign advance  = valid_s1 && take;
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1    <= text_byte;
			doc_end_s1 <= doc_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	hwt_step u_step (
		.text_byte (byte_s1),
		.doc_end   (doc_end_s1),
		.cur       (state_q),
		.nxt       (state_nxt),
		.res       (step_res)
	);

	// Only a byte that is actually present may produce a result.
	always_comb begin
		out_res       = step_res;
		out_res.valid = step_res.valid && valid_s1;
	end

	hwt_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (out_res),
		.take      (take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.word_char (word_char),
		.word_end  (word_end)
	);

endmodule
